// ----- hdl/qcv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcv_pkg: shared types and constants of the quadrature counter
// Field widths, register defaults, register indexes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package qcv_pkg;

  // Field widths.
  localparam int COUNT_W   = 16;
  localparam int VEL_W     = 32;
  localparam int GAIN_W    = 32;
  localparam int STOP_W    = 24;
  localparam int MIN_W     = 10;
  localparam int FILTER_W  = 10;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Product of the count magnitude and the gain.
  localparam int PROD_W = COUNT_W + GAIN_W;

  // Parameter defaults.
  localparam int ELAPSED_BITS_DEF = 32;
  localparam int FILTER_BITS_DEF  = 10;

  // Register reset values.
  localparam logic [GAIN_W-1:0]   GAIN_RST   = '0;
  localparam logic [STOP_W-1:0]   STOP_RST   = 24'd20000;
  localparam logic [MIN_W-1:0]    MIN_RST    = 10'd1;
  localparam logic [FILTER_W-1:0] FILTER_RST = 10'd12;

  // The count snaps back to zero when a step reaches either limit.
  localparam logic signed [COUNT_W:0] COUNT_HI = 17'sd32767;
  localparam logic signed [COUNT_W:0] COUNT_LO = -17'sd32768;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 2'd0,
    REG_STOP   = 2'd1,
    REG_MIN    = 2'd2,
    REG_FILTER = 2'd3
  } qcv_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;       // take the input word: filters, count, elapsed time
    logic stop;       // idle too long: velocity and elapsed time to zero
    logic mul;        // register count change times gain
    logic div_start;  // load the divider
    logic fin;        // write the saturated quotient back
    logic out_load;   // capture the result word
  } qcv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic upd;        // query needs a new velocity
    logic stop;       // query hits the idle limit
    logic div_busy;   // divider still iterating
  } qcv_sts_t;

endpackage

// ----- hdl/qcv_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcv_if: input and result channels of the quadrature counter
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface qcv_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic query;
  logic clear;

  modport source (output valid, output pin_a, output pin_b, output query,
                  output clear, input ready);
  modport sink   (input valid, input pin_a, input pin_b, input query,
                  input clear, output ready);
endinterface

interface qcv_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qcv_pkg::COUNT_W-1:0]  position_count;
  logic signed [qcv_pkg::VEL_W-1:0]    velocity;
  logic                                query_done;

  modport source (output valid, output position_count, output velocity,
                  output query_done, input ready);
  modport sink   (input valid, input position_count, input velocity,
                  input query_done, output ready);
endinterface

// ----- hdl/qcv_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcv_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qcv_div #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DVS_W:0]   trial;
  logic             fits;

  // Bring down the next dividend bit and try one subtraction.
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DVD_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == CNT_W'(1)) |=> !busy_r)
    else $error("divider kept running past its last step");

endmodule

// ----- hdl/qcv_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcv_datapath: pin filters, position count and velocity arithmetic
// Holds the configuration registers, tick state, multiplier, divider and the
// result register.
// ----------------------------------------------------------------------------
module qcv_datapath #(
  parameter int ELAPSED_BITS = qcv_pkg::ELAPSED_BITS_DEF,
  parameter int FILTER_BITS  = qcv_pkg::FILTER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [qcv_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [qcv_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               pin_a,
  input  logic                               pin_b,
  input  logic                               query,
  input  logic                               clear,
  input  qcv_pkg::qcv_cmd_t                  cmd,
  output qcv_pkg::qcv_sts_t                  sts,
  output logic signed [qcv_pkg::COUNT_W-1:0] position_count,
  output logic signed [qcv_pkg::VEL_W-1:0]   velocity,
  output logic                               query_done
);
  import qcv_pkg::*;

  localparam int CMP_W = (FILTER_BITS > FILTER_W) ? FILTER_BITS : FILTER_W;
  localparam int TW    = (ELAPSED_BITS > STOP_W) ? ELAPSED_BITS : STOP_W;

  // Configuration.
  logic [GAIN_W-1:0]   gain_r;
  logic [STOP_W-1:0]   stop_ticks_r;
  logic [MIN_W-1:0]    min_ticks_r;
  logic [FILTER_W-1:0] filter_ticks_r;

  // Tick state.
  logic                     filt_a_r, filt_b_r;
  logic [FILTER_BITS-1:0]   hold_a_r, hold_b_r;
  logic [COUNT_W-1:0]       count_r, last_count_r;
  logic [ELAPSED_BITS-1:0]  elapsed_r;
  logic [VEL_W-1:0]         vel_r;
  logic                     query_r;

  // Arithmetic.
  logic [PROD_W-1:0]        prod_r;
  logic                     neg_r;
  logic                     div_busy;
  logic [PROD_W-1:0]        quo;

  // Result register.
  logic [COUNT_W-1:0]       pos_out_r;
  logic [VEL_W-1:0]         vel_out_r;
  logic                     qd_out_r;

  // Filter: a new level is taken once it has differed for the threshold.
  function automatic logic [FILTER_BITS:0] pin_filter(
    input logic                   pin,
    input logic                   acc,
    input logic [FILTER_BITS-1:0] hold,
    input logic [FILTER_W-1:0]    thr
  );
    logic                   a;
    logic [FILTER_BITS-1:0] h;
    a = acc;
    h = hold;
    if (pin == acc) begin
      h = '0;
    end else begin
      if (h != '1) begin
        h = h + 1'b1;
      end
      if (CMP_W'(h) >= CMP_W'(thr)) begin
        a = pin;
        h = '0;
      end
    end
    return {a, h};
  endfunction

  logic [FILTER_BITS:0]     fa_nxt, fb_nxt;
  logic signed [COUNT_W:0]  cnt_ext, cnt_step;
  logic [COUNT_W-1:0]       count_nxt;
  logic [ELAPSED_BITS-1:0]  elapsed_inc;
  logic [COUNT_W-1:0]       diff, mag;
  logic [PROD_W-1:0]        prod_nxt;
  logic                     dt_gt_min, dt_gt_stop;
  logic                     quo_ovf;
  logic [VEL_W-1:0]         vel_sat;

  always_comb begin
    fa_nxt  = pin_filter(pin_a, filt_a_r, hold_a_r, filter_ticks_r);
    fb_nxt  = pin_filter(pin_b, filt_b_r, hold_b_r, filter_ticks_r);
    cnt_ext = {count_r[COUNT_W-1], count_r};
    cnt_step = fb_nxt[FILTER_BITS] ? (cnt_ext + 17'sd1) : (cnt_ext - 17'sd1);
    if (cnt_step >= COUNT_HI || cnt_step <= COUNT_LO) begin
      cnt_step = '0;
    end
    count_nxt = count_r;
    if (!filt_a_r && fa_nxt[FILTER_BITS]) begin
      count_nxt = cnt_step[COUNT_W-1:0];
    end
    if (clear) begin
      count_nxt = '0;
    end
  end

  assign elapsed_inc = (elapsed_r != '1) ? (elapsed_r + 1'b1) : elapsed_r;

  assign diff       = count_r - last_count_r;
  assign mag        = diff[COUNT_W-1] ? (COUNT_W'(0) - diff) : diff;
  assign prod_nxt   = PROD_W'(mag) * PROD_W'(gain_r);
  assign dt_gt_min  = TW'(elapsed_r) > TW'(min_ticks_r);
  assign dt_gt_stop = TW'(elapsed_r) > TW'(stop_ticks_r);

  assign sts.upd      = query_r && dt_gt_min && (diff != '0);
  assign sts.stop     = query_r && dt_gt_min && (diff == '0) && dt_gt_stop;
  assign sts.div_busy = div_busy;

  // Quotients of 2^31 and above clamp to the signed range.
  assign quo_ovf = |quo[PROD_W-1:VEL_W-1];
  always_comb begin
    if (!neg_r) begin
      vel_sat = quo_ovf ? {1'b0, {(VEL_W-1){1'b1}}} : quo[VEL_W-1:0];
    end else begin
      vel_sat = quo_ovf ? {1'b1, {(VEL_W-1){1'b0}}} : (VEL_W'(0) - quo[VEL_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r         <= GAIN_RST;
      stop_ticks_r   <= STOP_RST;
      min_ticks_r    <= MIN_RST;
      filter_ticks_r <= FILTER_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GAIN:   gain_r         <= cfg_wdata[GAIN_W-1:0];
        REG_STOP:   stop_ticks_r   <= cfg_wdata[STOP_W-1:0];
        REG_MIN:    min_ticks_r    <= cfg_wdata[MIN_W-1:0];
        REG_FILTER: filter_ticks_r <= cfg_wdata[FILTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_a_r     <= 1'b0;
      filt_b_r     <= 1'b0;
      hold_a_r     <= '0;
      hold_b_r     <= '0;
      count_r      <= '0;
      last_count_r <= '0;
      elapsed_r    <= '0;
      vel_r        <= '0;
      query_r      <= 1'b0;
    end else if (cmd.step) begin
      filt_a_r  <= fa_nxt[FILTER_BITS];
      hold_a_r  <= fa_nxt[FILTER_BITS-1:0];
      filt_b_r  <= fb_nxt[FILTER_BITS];
      hold_b_r  <= fb_nxt[FILTER_BITS-1:0];
      count_r   <= count_nxt;
      elapsed_r <= elapsed_inc;
      query_r   <= query;
    end else if (cmd.stop) begin
      vel_r     <= '0;
      elapsed_r <= '0;
    end else if (cmd.fin) begin
      vel_r        <= vel_sat;
      last_count_r <= count_r;
      elapsed_r    <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= prod_nxt;
      neg_r  <= diff[COUNT_W-1];
    end
    if (cmd.out_load) begin
      pos_out_r <= count_r;
      vel_out_r <= vel_r;
      qd_out_r  <= query_r;
    end
  end

  qcv_div #(
    .DVD_W (PROD_W),
    .DVS_W (ELAPSED_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (elapsed_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign position_count = pos_out_r;
  assign velocity       = vel_out_r;
  assign query_done     = qd_out_r;

  a_fin_clears_time: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && !cmd.step) |=> (elapsed_r == '0))
    else $error("elapsed time not cleared after a velocity update");

endmodule

// ----- hdl/qcv_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcv_ctrl: sequencer of the quadrature counter
// Steps one word through update, evaluation and, for a new velocity, multiply,
// divide and write-back, and owns the result valid flag.
// ----------------------------------------------------------------------------
module qcv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  qcv_pkg::qcv_sts_t sts,
  output qcv_pkg::qcv_cmd_t cmd
);
  import qcv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIVS,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.upd) begin
          state_nxt = S_MUL;
        end else begin
          cmd.stop  = sts.stop;
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_evals: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EVAL))
    else $error("accepted word not evaluated next cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("result register overwritten while still held");

  a_div_launched: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVS) |=> sts.div_busy)
    else $error("divider did not start");

endmodule

// ----- hdl/quadrature_count_velocity.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_count_velocity: quadrature encoder counter with velocity
// Glitch-filtered A/B pins drive a signed 16-bit position count; on a query
// the count change over the elapsed ticks gives a Q16.16 velocity.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Word contents
//   in_ch     sink       valid/ready      pin_a, pin_b, query, clear
//   out_ch    source     valid/ready      position_count, velocity, query_done
//   cfg_*     sink       write enable     cfg_idx selects, cfg_wdata carries
//
// A word that asks for no new velocity passes accept, evaluate and result
// capture. A query that computes a new velocity passes accept, evaluate,
// multiply, divider launch, the 48-step restoring divider (one quotient bit
// per cycle over the 48-bit product of count change and gain), divider
// done, write-back and capture.
// Reset is synchronous and active low; it loads the register defaults and
// clears the tick state, and there is no initialization pass afterwards.
// The result register lets the next word be accepted while the previous
// result waits; that word then stalls at capture until out_ch is free.
//
module quadrature_count_velocity #(
  parameter int ELAPSED_BITS = qcv_pkg::ELAPSED_BITS_DEF,
  parameter int FILTER_BITS  = qcv_pkg::FILTER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [qcv_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [qcv_pkg::CFG_W-1:0]     cfg_wdata,
  qcv_in_if.sink                        in_ch,
  qcv_out_if.source                     out_ch
);
  import qcv_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  qcv_cmd_t cmd;
  qcv_sts_t sts;

  // The sequencer decides which datapath step runs each cycle and owns both
  // handshakes; the datapath holds every piece of numeric state.
  qcv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath captures the input word on the step command, so its payload
  // only needs to be stable at the accepting edge.
  qcv_datapath #(
    .ELAPSED_BITS (ELAPSED_BITS),
    .FILTER_BITS  (FILTER_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .pin_a          (in_ch.pin_a),
    .pin_b          (in_ch.pin_b),
    .query          (in_ch.query),
    .clear          (in_ch.clear),
    .cmd            (cmd),
    .sts            (sts),
    .position_count (out_ch.position_count),
    .velocity       (out_ch.velocity),
    .query_done     (out_ch.query_done)
  );

endmodule

// ----- tb/quadrature_count_velocity_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_count_velocity_tb: self-checking bench for the encoder counter
// Feeds tick words through the input channel and checks every result word
// against a cycle-free model of the filters, the position count and the
// Q16.16 velocity estimate. Directed tests cover reset defaults, edges and
// clear, velocity saturation and filter extremes. The random tests replay
// quadrature motion with glitches under four idling mixes.
// ----------------------------------------------------------------------------
module quadrature_count_velocity_tb;
  import qcv_pkg::*;

  // One tick word as sent, and the result word it produces.
  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic query;
    logic clear;
  } tick_word_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] position_count;
    logic signed [VEL_W-1:0]   velocity;
    logic                      query_done;
  } tick_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  qcv_in_if  in_if ();
  qcv_out_if out_if ();

  quadrature_count_velocity dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  // 100 MHz clock: first rising edge at 5 ns.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the counter. The configuration copy is updated by write_config,
  // the state copy by advance_encoder, once per accepted tick word.
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]   cfg_gain;
  logic [STOP_W-1:0]   cfg_stop;
  logic [MIN_W-1:0]    cfg_min;
  logic [FILTER_W-1:0] cfg_filter;

  logic                      flt_a, flt_b;
  logic [FILTER_W-1:0]       hold_a, hold_b;
  logic signed [COUNT_W-1:0] pos, pos_at_update;
  logic [ELAPSED_BITS_DEF-1:0] ticks_since;
  logic signed [VEL_W-1:0]   vel;

  // Results still owed by the block, oldest first.
  tick_result_t tick_results_due[$];

  int mismatches = 0;
  int send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
  int recv_stall_pct = 0;  // chance in a hundred that the receiver stalls

  // Glitch filter: returns {accepted level, hold counter}. A level that keeps
  // differing from the accepted one is taken once the counter reaches the
  // filter setting; the counter saturates at its all-ones value.
  function automatic logic [FILTER_W:0] filter_next(input logic pin, input logic acc,
                                                    input logic [FILTER_W-1:0] hold);
    logic [FILTER_W-1:0] h;
    h = hold;
    if (pin == acc) return {acc, {FILTER_W{1'b0}}};
    if (h != '1) h = h + 1'b1;
    if (h >= cfg_filter) return {pin, {FILTER_W{1'b0}}};
    return {acc, h};
  endfunction

  // Applies one tick to the model state and returns the result word. The
  // order is fixed: filters, count step on a rising A, clear, elapsed time,
  // then the query.
  function automatic tick_result_t advance_encoder(input tick_word_t w);
    logic                      old_a;
    logic [FILTER_W:0]         nxt;
    int                        step_to;
    logic signed [COUNT_W-1:0] diff;
    longint                    mag, quo;
    tick_result_t              r;
    old_a = flt_a;
    nxt = filter_next(w.pin_a, flt_a, hold_a);
    flt_a = nxt[FILTER_W];
    hold_a = nxt[FILTER_W-1:0];
    nxt = filter_next(w.pin_b, flt_b, hold_b);
    flt_b = nxt[FILTER_W];
    hold_b = nxt[FILTER_W-1:0];

    // A step that lands on either limit sends the count back to zero.
    if (!old_a && flt_a) begin
      step_to = flt_b ? int'(pos) + 1 : int'(pos) - 1;
      if (step_to >= COUNT_HI || step_to <= COUNT_LO) step_to = 0;
      pos = step_to[COUNT_W-1:0];
    end
    if (w.clear) pos = '0;
    if (ticks_since != '1) ticks_since = ticks_since + 1'b1;

    if (w.query && ticks_since > cfg_min) begin
      // The count change wraps in 16 bits, so -32768 is a legal difference.
      diff = pos - pos_at_update;
      if (diff != 0) begin
        mag = longint'(diff);
        if (mag < 0) mag = -mag;
        mag = mag * longint'({32'd0, cfg_gain});
        quo = mag / longint'({32'd0, ticks_since});
        if (diff > 0)
          vel = (quo > 64'sd2147483647) ? 32'sh7FFF_FFFF : quo[31:0];
        else
          vel = (quo >= 64'sd2147483648) ? 32'sh8000_0000 : -quo[31:0];
        pos_at_update = pos;
        ticks_since = '0;
      end else if (ticks_since > cfg_stop) begin
        vel = '0;
        ticks_since = '0;
      end
    end

    r.position_count = pos;
    r.velocity = vel;
    r.query_done = w.query;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driving. Every task is entered just after a falling edge and returns just
  // after one, so inputs always change away from the sampling edge.
  // --------------------------------------------------------------------------

  // Sends one tick word. Valid stays high on return so back-to-back words
  // never see valid dropped and raised within one time step; it is lowered
  // only when the sender idles or stops sending.
  task automatic send_tick(input logic pa, input logic pb, input logic q, input logic c);
    tick_word_t w;
    w = '{pin_a: pa, pin_b: pb, query: q, clear: c};
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.pin_a <= pa;
    in_if.pin_b <= pb;
    in_if.query <= q;
    in_if.clear <= c;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    tick_results_due.push_back(advance_encoder(w));
    @(negedge clk);
  endtask

  // Stops sending and waits until every owed result has come back, plus a
  // further wait so the block has surely gone quiet.
  task automatic settle_counter();
    in_if.valid <= 1'b0;
    while (tick_results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Writes all four registers, one per cycle, then mirrors them in the model.
  task automatic write_config(input logic [GAIN_W-1:0] gain, input logic [STOP_W-1:0] stop,
                              input logic [MIN_W-1:0] minv, input logic [FILTER_W-1:0] filt);
    cfg_we <= 1'b1;
    cfg_idx <= REG_GAIN;
    cfg_wdata <= gain;
    @(negedge clk);
    cfg_idx <= REG_STOP;
    cfg_wdata <= {{(CFG_W-STOP_W){1'b0}}, stop};
    @(negedge clk);
    cfg_idx <= REG_MIN;
    cfg_wdata <= {{(CFG_W-MIN_W){1'b0}}, minv};
    @(negedge clk);
    cfg_idx <= REG_FILTER;
    cfg_wdata <= {{(CFG_W-FILTER_W){1'b0}}, filt};
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_gain = gain;
    cfg_stop = stop;
    cfg_min = minv;
    cfg_filter = filt;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the checker.
  // --------------------------------------------------------------------------
  always @(negedge clk) out_if.ready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (tick_results_due.size() == 0) begin
        flag_error($sformatf("unexpected result word: count %0d velocity %0d done %0b",
                             out_if.position_count, out_if.velocity, out_if.query_done));
      end else begin
        want = tick_results_due.pop_front();
        if (want.position_count !== out_if.position_count ||
            want.velocity !== out_if.velocity ||
            want.query_done !== out_if.query_done)
          flag_error($sformatf({"result word: count exp %0d got %0d, velocity exp %0d ",
                                "got %0d, done exp %0b got %0b"},
                               want.position_count, out_if.position_count,
                               want.velocity, out_if.velocity,
                               want.query_done, out_if.query_done));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: filter of 12 ticks, zero gain, min 1, stop 20000. A held
  // high for 12 ticks is accepted with B low, so the count steps down, and
  // the zero gain turns the change into zero velocity. A short low glitch on
  // A afterwards is rejected by the filter.
  task automatic test_reset_defaults();
    int k;
    for (k = 0; k < 12; k++) send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1, 1'b0);
    for (k = 0; k < 5; k++) send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);
  endtask

  // Filter off, unity gain: steps in both directions, a query inside the
  // minimum time, the stop rule, clear alone, clear on an edge and clear
  // together with a query.
  task automatic test_edges_and_clear();
    settle_counter();
    write_config(32'h0001_0000, 24'd3, 10'd2, 10'd0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);   // up
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);   // up, new velocity
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);   // too soon: stored velocity
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);   // down
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);   // negative velocity
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);   // no change, not yet past stop
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);   // past stop: velocity to zero
    send_tick(1'b1, 1'b1, 1'b0, 1'b1);   // edge and clear: clear wins
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);   // down from zero
    send_tick(1'b0, 1'b1, 1'b1, 1'b1);   // clear then query
  endtask

  // Full-scale gain: clear right after an update makes a large jump in one
  // tick, which saturates the velocity at both ends of the signed range.
  task automatic test_velocity_saturation();
    settle_counter();
    write_config(32'hFFFF_FFFF, 24'hFF_FFFF, 10'd0, 10'd0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b1);   // negative saturation
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b1);   // positive saturation
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);   // no change, stored velocity
  endtask

  // Filter of 2 rejects one-tick glitches and takes two-tick levels. Then the
  // largest filter setting: both pins must hold for 1023 ticks.
  task automatic test_filter_extremes();
    int k;
    settle_counter();
    write_config(32'h0003_0000, 24'd5000, 10'd10, 10'd2);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);   // glitch on both pins
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1, 1'b0);   // A taken on the second tick
    for (k = 0; k < 3; k++) send_tick(1'b0, 1'b0, 1'b0, 1'b0);

    settle_counter();
    write_config(32'h0003_0000, 24'd5000, 10'd10, 10'd1023);
    for (k = 1; k <= 1023; k++) send_tick(1'b1, 1'b1, (k % 100) == 0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);
  endtask

  // Quadrature motion with random direction changes and hold times just past
  // the filter setting. Some holds carry a glitch on one pin, and some
  // stretches are raw noise on both pins. Queries and clears are sprinkled in.
  task automatic drive_motion(input int words);
    int         sent, hold, k, glitch_at, glitch_len;
    logic [1:0] ph;
    logic       fwd, a, b, noisy;
    sent = 0;
    ph = 2'($urandom_range(3));
    fwd = 1'($urandom_range(1));
    while (sent < words) begin
      if ($urandom_range(9) == 0) begin
        hold = $urandom_range(1, 6);
        for (k = 0; k < hold; k++)
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                    $urandom_range(99) < 12, $urandom_range(99) < 3);
      end else begin
        if ($urandom_range(7) == 0) fwd = ~fwd;
        ph = fwd ? ph + 2'd1 : ph - 2'd1;
        a = ph[1];
        b = ph[1] ^ ph[0];
        hold = int'(cfg_filter) + $urandom_range(1, 3);
        glitch_at = ($urandom_range(5) == 0) ? $urandom_range(0, hold - 1) : -1;
        glitch_len = $urandom_range(1, int'(cfg_filter) + 1);
        for (k = 0; k < hold; k++) begin
          noisy = glitch_at >= 0 && k >= glitch_at && k < glitch_at + glitch_len;
          send_tick(a ^ (noisy & ph[0]), b ^ (noisy & ~ph[0]),
                    $urandom_range(99) < 12, $urandom_range(99) < 3);
        end
      end
      sent += hold;
    end
  endtask

  // One idling mix, two register settings of at least 30 words each; in the
  // middle of each, the sender waits until the block has answered every word.
  task automatic test_random_traffic(input int idle_p, input int stall_p, input int flavor);
    int half;
    send_idle_pct = idle_p;
    recv_stall_pct = stall_p;
    for (half = 0; half < 2; half++) begin
      settle_counter();
      case ((flavor + half) % 4)
        0: write_config($urandom, 24'd1, 10'd0, 10'd0);
        1: write_config(32'hFFFF_FFFF, 24'($urandom_range(16, 400)),
                        10'($urandom_range(0, 8)), 10'($urandom_range(1, 3)));
        2: write_config(32'($urandom_range(0, 1 << 20)), 24'hFF_FFFF,
                        10'($urandom_range(0, 4)), 10'($urandom_range(0, 2)));
        default: write_config($urandom, 24'($urandom_range(1, 2000)),
                              10'($urandom_range(0, 30)), 10'($urandom_range(0, 5)));
      endcase
      drive_motion(15);
      settle_counter();
      drive_motion(15);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_GAIN;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.pin_a = 1'b0;
    in_if.pin_b = 1'b0;
    in_if.query = 1'b0;
    in_if.clear = 1'b0;
    out_if.ready = 1'b0;

    // Model state after reset mirrors the register defaults.
    cfg_gain = GAIN_RST;
    cfg_stop = STOP_RST;
    cfg_min = MIN_RST;
    cfg_filter = FILTER_RST;
    flt_a = 1'b0;
    flt_b = 1'b0;
    hold_a = '0;
    hold_b = '0;
    pos = '0;
    pos_at_update = '0;
    ticks_since = '0;
    vel = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_edges_and_clear();
    test_velocity_saturation();
    test_filter_extremes();
    test_random_traffic(0, 0, 0);
    test_random_traffic(60, 0, 1);
    test_random_traffic(0, 60, 2);
    test_random_traffic(34, 34, 3);

    // Drain, then keep watching for stray words.
    in_if.valid <= 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && tick_results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/qcv_pkg.sv
hdl/qcv_if.sv
hdl/qcv_div.sv
hdl/qcv_datapath.sv
hdl/qcv_ctrl.sv
hdl/quadrature_count_velocity.sv
tb/quadrature_count_velocity_tb.sv
